[sv/pbfa_pkg.sv]
// Shared types and constants for the packet bit field access unit.
`timescale 1ns / 1ps

package pbfa_pkg;

  // Default byte buffer depth.
  localparam int BufferBytesDefault = 256;

  // Message length after reset, in bytes.
  localparam logic [8:0] MsgLenReset = 9'd256;

  // Access kinds carried by the op field.
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SETUP,
    S_ACCESS,
    S_DRAIN,
    S_EXTRACT,
    S_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic setup;
    logic issue;
    logic extract;
    logic result;
    logic clear_step;
  } pbfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic fit;
    logic issue_last;
    logic out_busy;
  } pbfa_status_t;

endpackage

[sv/pbfa_ctrl.sv]
// Controller state machine that sequences one bit field access at a time.
`timescale 1ns / 1ps

module pbfa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pbfa_pkg::pbfa_status_t st_i,
  output pbfa_pkg::pbfa_cmd_t    cmd_o
);
  import pbfa_pkg::*;

  state_e state_q, state_d;

  // State register; the buffer clearing pass runs first after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (st_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = st_i.fit ? S_ACCESS : S_RESULT;
      end
      S_ACCESS: begin
        cmd_o.issue = 1'b1;
        if (st_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EXTRACT;
      end
      S_EXTRACT: begin
        cmd_o.extract = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!st_i.out_busy) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted item always moves on to the bounds check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CHECK)
    else $error("accepted item did not enter the check state");

  // Buffer reads are only issued for fields that passed the bounds check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> st_i.fit)
    else $error("buffer access issued for an out-of-range field");

  // The clearing pass does not end early.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR && !st_i.clear_last |=> state_q == S_CLEAR)
    else $error("clearing pass left before the last entry");
`endif

endmodule

[sv/pbfa_datapath.sv]
// Datapath: item registers, bounds check, byte buffer, field window and result register.
`timescale 1ns / 1ps

module pbfa_datapath #(
  parameter int BUFFER_BYTES = pbfa_pkg::BufferBytesDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pbfa_pkg::pbfa_cmd_t    cmd_i,
  output pbfa_pkg::pbfa_status_t st_o,
  input  logic                   op_i,
  input  logic                   big_endian_i,
  input  logic                   sign_extend_i,
  input  logic [10:0]            bit_offset_i,
  input  logic [6:0]             field_length_i,
  input  logic [63:0]            write_value_i,
  input  logic                   cfg_write_i,
  input  logic [8:0]             cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            read_value_o,
  output logic                   in_range_o
);
  import pbfa_pkg::*;

  localparam int              AddrW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [12:0]     BufBytes = 13'(BUFFER_BYTES);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(BUFFER_BYTES - 1);
  localparam logic [3:0]      TopSlot  = 4'd8;

  // Low len bits set; len of 64 or more gives all ones.
  function automatic logic [63:0] field_mask(input logic [6:0] len);
    logic [63:0] m;
    m = (len >= 7'd64) ? '1 : ((64'd1 << len) - 64'd1);
    return m;
  endfunction

  // Window slot of the k-th touched byte: big-endian fills from the top.
  function automatic logic [3:0] win_slot(input logic be, input logic [3:0] k);
    logic [3:0] s;
    s = be ? (TopSlot - k) : k;
    return s;
  endfunction

  // Item and configuration registers.
  op_e         op_q;
  logic        be_q, sx_q;
  logic [10:0] off_q;
  logic [6:0]  len_q;
  logic [63:0] wv_q;
  logic [8:0]  msg_len_q;

  // Access working registers.
  logic            fit_q;
  logic [3:0]      nbytes_q;
  logic [6:0]      sh_q;
  logic [3:0]      k_q;
  logic            rd_pend_q;
  logic [3:0]      rd_k_q;
  logic [7:0]      rdata_q;
  logic [8:0][7:0] win_q, wmask_q, wdata_q;
  logic [63:0]     rv_q;
  logic [AddrW-1:0] clr_q;

  // Result register.
  logic        out_valid_q, in_range_q;
  logic [63:0] read_value_q;

  logic [7:0] mem [BUFFER_BYTES];

  // Capture the item fields on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(op_i);
      be_q  <= big_endian_i;
      sx_q  <= sign_extend_i;
      off_q <= bit_offset_i;
      len_q <= field_length_i;
      wv_q  <= write_value_i;
    end
  end

  // Message length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q <= MsgLenReset;
    end else if (cfg_write_i) begin
      msg_len_q <= cfg_data_i;
    end
  end

  // Bounds check against the length saturated at the buffer size.
  logic [12:0] eff_len;
  logic [15:0] end_bit, lim_bit;
  logic        fit;
  logic [7:0]  span;
  logic [6:0]  shift_amt;

  assign eff_len = ({4'd0, msg_len_q} > BufBytes) ? BufBytes : {4'd0, msg_len_q};
  assign end_bit = 16'(off_q) + 16'(len_q);
  assign lim_bit = {eff_len, 3'd0};
  assign fit     = (len_q != 7'd0) && (len_q <= 7'd64) && (end_bit <= lim_bit);

  // Bytes touched and the window shift that aligns the field to bit zero.
  assign span      = 8'(off_q[2:0]) + 8'(len_q) + 8'd7;
  assign shift_amt = be_q ? 7'(7'd72 - 7'(off_q[2:0]) - len_q) : 7'(off_q[2:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      fit_q    <= fit;
      nbytes_q <= 4'(span >> 3);
      sh_q     <= shift_amt;
    end
  end

  // Field mask and write data laid into the window.
  logic [63:0] fmask;
  assign fmask = field_mask(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      wmask_q <= 72'(fmask) << sh_q;
      wdata_q <= 72'(wv_q & fmask) << sh_q;
    end
  end

  // Byte counter of the access loop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      k_q <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + 4'd1;
    end
  end

  // Read return pipeline: the read data is registered, and rd_pend_q marks it valid in the cycle after the address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= k_q;
  end

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // Buffer addressing and read-modify-write merge.
  logic [15:0]      rd_sum, wr_sum;
  logic [AddrW-1:0] rd_addr, wr_addr, mem_waddr;
  logic [3:0]       ret_slot;
  logic [7:0]       merged, mem_wdata;
  logic             mem_we;

  assign rd_sum   = 16'(off_q[10:3]) + 16'(k_q);
  assign wr_sum   = 16'(off_q[10:3]) + 16'(rd_k_q);
  assign rd_addr  = rd_sum[AddrW-1:0];
  assign wr_addr  = wr_sum[AddrW-1:0];
  assign ret_slot = win_slot(be_q, rd_k_q);
  assign merged   = (rdata_q & ~wmask_q[ret_slot]) | wdata_q[ret_slot];

  assign mem_we    = cmd_i.clear_step || (rd_pend_q && (op_q == OP_WRITE));
  assign mem_waddr = cmd_i.clear_step ? clr_q : wr_addr;
  assign mem_wdata = cmd_i.clear_step ? 8'd0 : merged;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Gather returned bytes into the window.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      win_q <= '0;
    end else if (rd_pend_q) begin
      win_q[ret_slot] <= rdata_q;
    end
  end

  // Align the field to bit zero and mask it.
  logic [71:0] win_shift;
  assign win_shift = 72'(win_q) >> sh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.extract) begin
      rv_q <= win_shift[63:0] & fmask;
    end
  end

  // Sign extension and gating of the final value.
  logic        sign_bit;
  logic [63:0] rv_ext, result_value;

  assign sign_bit     = rv_q[6'(len_q - 7'd1)];
  assign rv_ext       = (sx_q && (len_q < 7'd64) && sign_bit) ? (rv_q | ~fmask) : rv_q;
  assign result_value = (fit_q && (op_q == OP_READ)) ? rv_ext : '0;

  // Output register: holds one finished item until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      read_value_q <= result_value;
      in_range_q   <= fit_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign in_range_o   = in_range_q;

  // Status to the controller.
  assign st_o.clear_last = (clr_q == LastAddr);
  assign st_o.fit        = fit_q;
  assign st_o.issue_last = (k_q == 4'(nbytes_q - 4'd1));
  assign st_o.out_busy   = out_valid_q && !out_ready_i;

`ifndef ASSERT_OFF
  // The merge write never targets the byte being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue && mem_we |-> rd_addr != mem_waddr)
    else $error("buffer read and write collide on one address");

  // A new result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while occupied");

  // A failed access reports zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !in_range_q |-> read_value_q == '0)
    else $error("failed access returned a nonzero value");
`endif

endmodule

[sv/packet_bit_field_access_unit.sv]
// Top level of the packet bit field access unit.
`timescale 1ns / 1ps

// Holds one message in a byte buffer of BUFFER_BYTES bytes and serves read or
// write accesses to bit fields of 1 to 64 bits at any bit offset, in
// little-endian or big-endian bit order, with optional sign extension on reads.
// A field that ends past the message length fails: in_range_o is 0, the value
// is 0 and the buffer is unchanged. One item is processed at a time. An access
// touching n bytes (1 to 9) passes the check, setup, access, drain, extract and
// result states before the next item is taken; its access state reads the bytes
// through the buffer's single read port, one byte per cycle, with merged
// write-back overlapped on the write port. A failed access goes from setup
// straight to the result state. After reset a clearing pass zeroes the buffer,
// during which no item is accepted; configuration writes are taken at any time.
module packet_bit_field_access_unit #(
  parameter int BUFFER_BYTES = pbfa_pkg::BufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic        big_endian_i,
  input  logic        sign_extend_i,
  input  logic [10:0] bit_offset_i,
  input  logic [6:0]  field_length_i,
  input  logic [63:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] read_value_o,
  output logic        in_range_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  import pbfa_pkg::*;

  pbfa_cmd_t    cmd;
  pbfa_status_t st;

  // The length register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Access sequencer.
  pbfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Buffer and field datapath.
  pbfa_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .op_i           (op_i),
    .big_endian_i   (big_endian_i),
    .sign_extend_i  (sign_extend_i),
    .bit_offset_i   (bit_offset_i),
    .field_length_i (field_length_i),
    .write_value_i  (write_value_i),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .in_range_o     (in_range_o)
  );

endmodule

[verif/pbfa_access_checker.sv]
// Checker that predicts and compares every bit field access of the unit.
`timescale 1ns / 1ps

module pbfa_access_checker #(
  parameter int BUFFER_BYTES = pbfa_pkg::BufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic        big_endian_i,
  input  logic        sign_extend_i,
  input  logic [10:0] bit_offset_i,
  input  logic [6:0]  field_length_i,
  input  logic [63:0] write_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] read_value_i,
  input  logic        in_range_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [8:0]  cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);
  import pbfa_pkg::*;

  // One result item as the unit should deliver it.
  typedef struct packed {
    logic [63:0] read_value;
    logic        in_range;
  } access_result_t;

  logic [7:0]     msg_bytes [BUFFER_BYTES];
  logic [8:0]     msg_len;
  access_result_t result_q [$];
  int             mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // Applies one access to the shadow buffer and returns the result it gives.
  function automatic access_result_t apply_access(input op_e op, input logic be,
      input logic sx, input logic [10:0] offset, input logic [6:0] len,
      input logic [63:0] wv);
    access_result_t res;
    int limit_bits;
    int pos;
    int fbit;
    int idx;
    int sh;
    int i;
    res = '0;
    limit_bits = (int'(msg_len) > BUFFER_BYTES) ? BUFFER_BYTES * 8 : int'(msg_len) * 8;
    // Zero, oversized and overrunning fields all fail the same way.
    if (len == 7'd0 || len > 7'd64 || int'(offset) + int'(len) > limit_bits) begin
      return res;
    end
    for (i = 0; i < int'(len); i++) begin
      pos  = int'(offset) + i;
      fbit = be ? int'(len) - 1 - i : i;
      idx  = (pos / 8) % BUFFER_BYTES;
      sh   = be ? 7 - pos % 8 : pos % 8;
      if (op == OP_READ) begin
        res.read_value[fbit] = msg_bytes[idx][sh];
      end else begin
        msg_bytes[idx][sh] = wv[fbit];
      end
    end
    // Sign extension applies to reads only; a full-width field stays as it is.
    if (op == OP_READ && sx && len < 7'd64 && res.read_value[len - 1]) begin
      res.read_value = res.read_value | ({64{1'b1}} << len);
    end
    if (op == OP_WRITE) begin
      res.read_value = '0;
    end
    res.in_range = 1'b1;
    return res;
  endfunction

  // Reports the first few mismatches in full and counts all of them.
  task automatic note_mismatch(input string what, input logic [63:0] want_v,
      input logic [63:0] got_v);
    if (mismatch_count < 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
    end
    mismatch_count++;
  endtask

  // Tracks configuration, checks result items and queues new expectations.
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    int b;
    if (!rst_ni) begin
      for (b = 0; b < BUFFER_BYTES; b++) begin
        msg_bytes[b] = '0;
      end
      msg_len = MsgLenReset;
      result_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        msg_len = cfg_data_i;
      end
      // A result leaves before a new item enters within the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          note_mismatch("unexpected result item", '0, read_value_i);
        end else begin
          want = result_q.pop_front();
          if (read_value_i !== want.read_value) begin
            note_mismatch("read_value", want.read_value, read_value_i);
          end
          if (in_range_i !== want.in_range) begin
            note_mismatch("in_range", 64'(want.in_range), 64'(in_range_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(apply_access(op_e'(op_i), big_endian_i, sign_extend_i,
                                        bit_offset_i, field_length_i, write_value_i));
      end
    end
    pending_o = result_q.size();
  end

endmodule

[verif/tb_packet_bit_field_access_unit.sv]
// Testbench top for the packet bit field access unit: stimulus and verdict.
`timescale 1ns / 1ps

module tb_packet_bit_field_access_unit;
  import pbfa_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int DrainCycles   = 24;
  localparam int PhaseCount    = 10;
  localparam int ItemsPerPhase = 120;

  // Receiver behavior, redrawn at random during the run.
  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        acc_op = 1'b0;
  logic        acc_big_endian = 1'b0;
  logic        acc_sign_extend = 1'b0;
  logic [10:0] acc_offset = '0;
  logic [6:0]  acc_len = '0;
  logic [63:0] acc_wdata = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] read_value;
  logic        in_range;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  // Stimulus-side view of the message length and the most recent write.
  logic [8:0]  msg_len_now = MsgLenReset;
  logic        have_write = 1'b0;
  logic [10:0] last_wr_offset = '0;
  logic [6:0]  last_wr_len = '0;
  logic        last_wr_be = 1'b0;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packet_bit_field_access_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (acc_op),
    .big_endian_i  (acc_big_endian),
    .sign_extend_i (acc_sign_extend),
    .bit_offset_i  (acc_offset),
    .field_length_i(acc_len),
    .write_value_i (acc_wdata),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_value_o  (read_value),
    .in_range_o    (in_range),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  pbfa_access_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (acc_op),
    .big_endian_i  (acc_big_endian),
    .sign_extend_i (acc_sign_extend),
    .bit_offset_i  (acc_offset),
    .field_length_i(acc_len),
    .write_value_i (acc_wdata),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .read_value_i  (read_value),
    .in_range_i    (in_range),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[packet_bit_field_access_unit] ERROR");
      $finish;
    end
  end

  // Receiver stalls follow a mode that is redrawn at random during the run.
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
    end
    case (ready_mode)
      READY_ALWAYS: begin
        out_ready <= 1'b1;
      end
      READY_MOSTLY: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      READY_RARELY: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ((cycle_count / 5) % 2 == 0);
      end
    endcase
  end

  // Offers one item, holds it until taken, then applies burst and gap pacing.
  task automatic send_access(input op_e op, input logic be, input logic sx,
      input logic [10:0] offset, input logic [6:0] len, input logic [63:0] wv);
    int gap;
    in_valid        <= 1'b1;
    acc_op          <= op;
    acc_big_endian  <= be;
    acc_sign_extend <= sx;
    acc_offset      <= offset;
    acc_len         <= len;
    acc_wdata       <= wv;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds off new items until every result is back and the unit has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes the message length once the unit is idle.
  task automatic write_msg_len(input logic [8:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid   <= 1'b0;
    msg_len_now = value;
  endtask

  // Draws one access: mostly a field that fits the message, often a read back
  // of the last write, sometimes an overrunning or malformed field.
  task automatic send_random_access();
    int          limit_bits;
    int          len;
    int          offset;
    int          kind;
    logic        be;
    op_e         op;
    logic [63:0] wv;
    limit_bits = (int'(msg_len_now) > BufferBytesDefault) ?
                 BufferBytesDefault * 8 : int'(msg_len_now) * 8;
    kind = $urandom_range(0, 99);
    op   = op_e'($urandom_range(0, 1));
    be   = 1'($urandom_range(0, 1));
    wv   = ($urandom_range(0, 7) == 0) ? {64{1'b1}} : {$urandom, $urandom};
    if (kind < 6) begin
      len    = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      offset = $urandom_range(0, 2047);
    end else if (kind < 14) begin
      len    = $urandom_range(1, 64);
      offset = $urandom_range(0, 2047);
    end else if (kind < 40 && have_write) begin
      op     = OP_READ;
      len    = int'(last_wr_len);
      offset = int'(last_wr_offset);
      be     = last_wr_be;
    end else begin
      case ($urandom_range(0, 9))
        0: len = 64;
        1: len = 1;
        default: len = $urandom_range(1, 64);
      endcase
      if (limit_bits >= len) begin
        offset = ($urandom_range(0, 7) == 0) ? limit_bits - len :
                 $urandom_range(0, limit_bits - len);
      end else begin
        offset = $urandom_range(0, 15);
      end
    end
    if (op == OP_WRITE) begin
      have_write     = 1'b1;
      last_wr_offset = 11'(offset);
      last_wr_len    = 7'(len);
      last_wr_be     = be;
    end
    send_access(op, be, 1'($urandom_range(0, 1)), 11'(offset), 7'(len), wv);
  endtask

  // Main sequence: reset, directed accesses, then randomized phases.
  initial begin
    logic [8:0] len_sel;
    int p;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-width fields in both bit orders, including a nine-byte span.
    send_access(OP_WRITE, 1'b0, 1'b0, 11'd0, 7'd64, 64'h0123_4567_89AB_CDEF);
    send_access(OP_READ, 1'b0, 1'b1, 11'd0, 7'd64, '0);
    send_access(OP_READ, 1'b1, 1'b0, 11'd0, 7'd64, '0);
    send_access(OP_READ, 1'b0, 1'b1, 11'd4, 7'd8, '0);
    send_access(OP_WRITE, 1'b1, 1'b1, 11'd3, 7'd64, 64'hFEDC_BA98_7654_3210);
    send_access(OP_READ, 1'b1, 1'b0, 11'd3, 7'd64, '0);
    send_access(OP_READ, 1'b1, 1'b1, 11'd3, 7'd12, '0);
    // Last bit of the buffer, with write masking and sign extension.
    send_access(OP_WRITE, 1'b0, 1'b0, 11'd2047, 7'd1, {64{1'b1}});
    send_access(OP_READ, 1'b0, 1'b1, 11'd2047, 7'd1, '0);
    send_access(OP_READ, 1'b1, 1'b0, 11'd1984, 7'd64, '0);
    send_access(OP_READ, 1'b0, 1'b0, 11'd1985, 7'd64, '0);
    // A failed write must leave the buffer untouched.
    send_access(OP_WRITE, 1'b0, 1'b0, 11'd2040, 7'd16, 64'hFFFF);
    send_access(OP_READ, 1'b0, 1'b0, 11'd2040, 7'd8, '0);
    // Zero and oversized field lengths, then mixed in-range accesses.
    send_access(OP_READ, 1'b0, 1'b0, 11'd0, 7'd0, '0);
    send_access(OP_WRITE, 1'b1, 1'b0, 11'd0, 7'd65, {64{1'b1}});
    send_access(OP_READ, 1'b0, 1'b1, 11'd0, 7'd127, '0);
    send_access(OP_WRITE, 1'b0, 1'b1, 11'd13, 7'd13, {64{1'b1}});
    send_access(OP_READ, 1'b0, 1'b0, 11'd8, 7'd32, '0);
    send_access(OP_WRITE, 1'b1, 1'b0, 11'd100, 7'd33, '0);
    send_access(OP_READ, 1'b1, 1'b1, 11'd96, 7'd40, '0);
    send_access(OP_READ, 1'b0, 1'b1, 11'd0, 7'd1, '0);

    // Message length extremes: empty, one byte, and saturation above the buffer.
    write_msg_len(9'd0);
    send_access(OP_READ, 1'b0, 1'b0, 11'd0, 7'd1, '0);
    write_msg_len(9'd1);
    send_access(OP_READ, 1'b1, 1'b1, 11'd0, 7'd8, '0);
    send_access(OP_READ, 1'b0, 1'b0, 11'd1, 7'd8, '0);
    write_msg_len(9'd511);
    send_access(OP_READ, 1'b1, 1'b0, 11'd1984, 7'd64, '0);
    write_msg_len(9'd257);
    send_access(OP_READ, 1'b0, 1'b1, 11'd1984, 7'd64, '0);

    // Random phases, each under its own message length.
    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        0: len_sel = 9'd256;
        1: len_sel = 9'd511;
        2: len_sel = 9'd2;
        3: len_sel = 9'd0;
        4: len_sel = 9'd255;
        5: len_sel = 9'd1;
        6: len_sel = 9'd256;
        default: len_sel = 9'($urandom_range(0, 511));
      endcase
      write_msg_len(len_sel);
      for (n = 0; n < ItemsPerPhase; n++) begin
        // One pause in the middle of the first phase lets the unit run completely dry.
        if (p == 0 && n == ItemsPerPhase / 2) begin
          wait_idle();
        end
        send_random_access();
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("[packet_bit_field_access_unit] OK");
    end else begin
      $display("[packet_bit_field_access_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pbfa_pkg.sv
sv/pbfa_ctrl.sv
sv/pbfa_datapath.sv
sv/packet_bit_field_access_unit.sv
verif/pbfa_access_checker.sv
verif/tb_packet_bit_field_access_unit.sv
